// ===== design/ppc_pkg.sv =====
// Shared types and constants for the point-in-polygon crossing test.
// No dependencies; ppc_front, ppc_back and the top refer to this package by scope.
package ppc_pkg;

    localparam int COORD_BITS_DEFAULT   = 32;
    localparam int QUEUE_DEPTH_DEFAULT  = 4;
    localparam int RESULT_DEPTH_DEFAULT = 2;

    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_Y = 2'd1;

    // Classification of one edge, carried with its differences.
    typedef struct packed {
        logic straddle;
        logic da_neg;
        logic last;
    } t_edge_flags;

endpackage

// ===== design/ppc_fifo.sv =====
// Small first-in first-out queue held in flip-flops, show-ahead read.
// Uses no package; widths and depth come from its parameters.
module ppc_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                do_wr, do_rd;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("word written into a full queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a write");
`endif

endmodule

// ===== design/ppc_front.sv =====
// Front end: holds the query point registers and turns each edge into the
// differences and flags the crossing test needs. Depends on ppc_pkg.
module ppc_front #(
    parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ppc_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [ppc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic [COORD_BITS-1:0]               i_edge_x1,
    input  logic [COORD_BITS-1:0]               i_edge_y1,
    input  logic [COORD_BITS-1:0]               i_edge_x2,
    input  logic [COORD_BITS-1:0]               i_edge_y2,
    input  logic                                i_last_edge,
    output ppc_pkg::t_edge_flags                o_flags,
    output logic [4*(COORD_BITS+1)-1:0]         o_data
);

    localparam int W  = COORD_BITS + 1;
    localparam int DB = ppc_pkg::CFG_DATA_BITS;

    logic [DB-1:0]         r_point_x, n_point_x;
    logic [DB-1:0]         r_point_y, n_point_y;
    logic [COORD_BITS-1:0] px_cb, py_cb;
    logic signed [W-1:0]   x1_s, y1_s, x2_s, y2_s, px_s, py_s;
    logic signed [W-1:0]   dx1, dy, da, db, dx;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_point_x = r_point_x;
        n_point_y = r_point_y;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                ppc_pkg::CFG_POINT_X: n_point_x = i_cfg_data;
                ppc_pkg::CFG_POINT_Y: n_point_y = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_x <= '0;
            r_point_y <= '0;
        end else begin
            r_point_x <= n_point_x;
            r_point_y <= n_point_y;
        end
    end

    // A register narrower than the coordinate is taken as unsigned.
    generate
        if (COORD_BITS <= DB) begin : g_narrow
            assign px_cb = r_point_x[COORD_BITS-1:0];
            assign py_cb = r_point_y[COORD_BITS-1:0];
        end else begin : g_wide
            assign px_cb = {{(COORD_BITS-DB){1'b0}}, r_point_x};
            assign py_cb = {{(COORD_BITS-DB){1'b0}}, r_point_y};
        end
    endgenerate

    assign x1_s = W'($signed(i_edge_x1));
    assign y1_s = W'($signed(i_edge_y1));
    assign x2_s = W'($signed(i_edge_x2));
    assign y2_s = W'($signed(i_edge_y2));
    assign px_s = W'($signed(px_cb));
    assign py_s = W'($signed(py_cb));

    assign dx1 = x1_s - px_s;
    assign dy  = y1_s - y2_s;
    assign da  = y1_s - py_s;
    assign db  = y2_s - py_s;
    assign dx  = x2_s - x1_s;

    assign o_flags.straddle = da[W-1] ^ db[W-1];
    assign o_flags.da_neg   = da[W-1];
    assign o_flags.last     = i_last_edge;
    assign o_data           = {dx1, dy, da, dx};

endmodule

// ===== design/ppc_back.sv =====
// Back end: split multiplies of the two cross terms over two register stages,
// then the sign test and the parity bit. Depends on ppc_pkg.
module ppc_back #(
    parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  ppc_pkg::t_edge_flags        i_flags,
    input  logic [4*(COORD_BITS+1)-1:0] i_data,
    output logic                        o_pop,
    input  logic                        i_out_full,
    output logic                        o_push,
    output logic                        o_inside
);

    localparam int W = COORD_BITS + 1;
    localparam int L = (W + 1) / 2;
    localparam int H = W - L;

    logic signed [W-1:0] a, b, c, d;
    logic signed [H-1:0] a_h, b_h, c_h, d_h;
    logic [L-1:0]        a_l, b_l, c_l, d_l;

    logic signed [2*H-1:0]   n_hh1, n_hh2;
    logic signed [H+L:0]     n_hl1, n_lh1, n_hl2, n_lh2;
    logic [2*L-1:0]          n_ll1, n_ll2;

    logic                    r_a_valid;
    ppc_pkg::t_edge_flags    r_a_flags;
    logic signed [2*H-1:0]   r_hh1, r_hh2;
    logic signed [H+L:0]     r_hl1, r_lh1, r_hl2, r_lh2;
    logic [2*L-1:0]          r_ll1, r_ll2;

    logic signed [W+1:0]     mid1, mid2;
    logic signed [2*W-1:0]   n_p1, n_p2;

    logic                    r_b_valid;
    ppc_pkg::t_edge_flags    r_b_flags;
    logic signed [2*W-1:0]   r_p1, r_p2;

    logic signed [2*W:0]     n_sum;
    logic                    crosses, en;
    logic                    r_parity, n_parity;

    // Terms: a*b + c*d with a = x1-px, b = y1-y2, c = y1-py, d = x2-x1.
    assign {a, b, c, d} = i_data;
    assign a_h = a[W-1:L];
    assign b_h = b[W-1:L];
    assign c_h = c[W-1:L];
    assign d_h = d[W-1:L];
    assign a_l = a[L-1:0];
    assign b_l = b[L-1:0];
    assign c_l = c[L-1:0];
    assign d_l = d[L-1:0];

    assign n_hh1 = a_h * b_h;
    assign n_hl1 = a_h * $signed({1'b0, b_l});
    assign n_lh1 = $signed({1'b0, a_l}) * b_h;
    assign n_ll1 = a_l * b_l;
    assign n_hh2 = c_h * d_h;
    assign n_hl2 = c_h * $signed({1'b0, d_l});
    assign n_lh2 = $signed({1'b0, c_l}) * d_h;
    assign n_ll2 = c_l * d_l;

    // The high and low products do not overlap, so they join by concatenation.
    assign mid1 = (W+2)'(r_hl1) + (W+2)'(r_lh1);
    assign mid2 = (W+2)'(r_hl2) + (W+2)'(r_lh2);
    assign n_p1 = $signed({r_hh1, r_ll1}) + ((2*W)'(mid1) <<< L);
    assign n_p2 = $signed({r_hh2, r_ll2}) + ((2*W)'(mid2) <<< L);

    assign n_sum = (2*W+1)'(r_p1) + (2*W+1)'(r_p2);

    always_comb begin
        crosses = 1'b0;
        if (r_b_flags.straddle) begin
            if (r_b_flags.da_neg) begin
                crosses = n_sum[2*W];
            end else begin
                crosses = !n_sum[2*W] && (|n_sum);
            end
        end
    end

    // Hold the whole pipe only while a result waits for room.
    assign en       = !(r_b_valid && r_b_flags.last && i_out_full);
    assign o_pop    = en && i_valid;
    assign o_push   = en && r_b_valid && r_b_flags.last;
    assign o_inside = r_parity ^ crosses;

    always_comb begin
        n_parity = r_parity;
        if (en && r_b_valid) begin
            n_parity = r_b_flags.last ? 1'b0 : (r_parity ^ crosses);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_parity  <= 1'b0;
        end else begin
            if (en) begin
                r_a_valid <= i_valid;
                r_b_valid <= r_a_valid;
            end
            r_parity <= n_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_flags <= i_flags;
            r_hh1     <= n_hh1;
            r_hl1     <= n_hl1;
            r_lh1     <= n_lh1;
            r_ll1     <= n_ll1;
            r_hh2     <= n_hh2;
            r_hl2     <= n_hl2;
            r_lh2     <= n_lh2;
            r_ll2     <= n_ll2;
            r_b_flags <= r_a_flags;
            r_p1      <= n_p1;
            r_p2      <= n_p2;
        end
    end

`ifndef SYNTH
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_out_full)
        else $error("result pushed into a full result queue");
    a_parity_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_b_valid && r_b_flags.last) |=> !r_parity)
        else $error("parity not cleared after the last edge");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_b_valid && $stable(r_p1) && $stable(r_p2)))
        else $error("back pipe moved while stalled");
`endif

endmodule

// ===== design/point_in_polygon_crossing.sv =====
// Even-odd point-in-polygon test: write the query point through the config
// channel, then push the polygon's edges one word per cycle, with last_edge set
// on the closing edge; one result word (inside flag) comes out per polygon.
// Edges are taken every cycle while the edge queue has room; the back end's
// three stages (split multiply, product sum, sign test and parity) run one edge
// per cycle unless stalled; a result is pushed while its last edge is held in
// the product-sum register. Only a full result queue stalls the back end.
// Depends on ppc_pkg, ppc_front, ppc_fifo and ppc_back.
module point_in_polygon_crossing #(
    parameter int COORD_BITS   = ppc_pkg::COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH  = ppc_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int RESULT_DEPTH = ppc_pkg::RESULT_DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ppc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ppc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [COORD_BITS-1:0]              i_edge_x1,
    input  logic [COORD_BITS-1:0]              i_edge_y1,
    input  logic [COORD_BITS-1:0]              i_edge_x2,
    input  logic [COORD_BITS-1:0]              i_edge_y2,
    input  logic                               i_last_edge,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_inside_res
);

    localparam int W  = COORD_BITS + 1;
    localparam int FB = $bits(ppc_pkg::t_edge_flags);
    localparam int QW = FB + 4 * W;

    ppc_pkg::t_edge_flags front_flags, back_flags;
    logic [4*W-1:0]       front_data, back_data;
    logic [QW-1:0]        q_rdata;
    logic                 q_empty, q_pop;
    logic                 res_full, res_push, res_bit;

    ppc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_edge_x1   (i_edge_x1),
        .i_edge_y1   (i_edge_y1),
        .i_edge_x2   (i_edge_x2),
        .i_edge_y2   (i_edge_y2),
        .i_last_edge (i_last_edge),
        .o_flags     (front_flags),
        .o_data      (front_data)
    );

    ppc_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_edge_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push && !full),
        .i_wdata ({front_flags, front_data}),
        .i_rd    (q_pop),
        .o_rdata (q_rdata),
        .o_full  (full),
        .o_empty (q_empty)
    );

    assign {back_flags, back_data} = q_rdata;

    ppc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!q_empty),
        .i_flags    (back_flags),
        .i_data     (back_data),
        .o_pop      (q_pop),
        .i_out_full (res_full),
        .o_push     (res_push),
        .o_inside   (res_bit)
    );

    ppc_fifo #(
        .WIDTH (1),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_bit),
        .i_rd    (pop),
        .o_rdata (o_inside_res),
        .o_full  (res_full),
        .o_empty (empty)
    );

endmodule

// ===== bench/ppc_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for point_in_polygon_crossing: tracks the query point and crossing parity,
// predicts the inside flag on each closing edge and compares popped words.
// Depends on ppc_pkg for the config index codes and coordinate width.
module ppc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic [ppc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ppc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               push,
    input  logic                               full,
    input  logic [ppc_pkg::COORD_BITS_DEFAULT-1:0] i_edge_x1,
    input  logic [ppc_pkg::COORD_BITS_DEFAULT-1:0] i_edge_y1,
    input  logic [ppc_pkg::COORD_BITS_DEFAULT-1:0] i_edge_x2,
    input  logic [ppc_pkg::COORD_BITS_DEFAULT-1:0] i_edge_y2,
    input  logic                               i_last_edge,
    input  logic                               empty,
    input  logic                               pop,
    input  logic                               o_inside_res,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_edges,
    output int                                 o_results,
    output int                                 o_writes
);

    localparam int CW = ppc_pkg::COORD_BITS_DEFAULT;

    logic [CW-1:0] query_x;
    logic [CW-1:0] query_y;
    logic          odd_crossings;
    bit            inside_expected[$];

    // Exact crossing test: sums of 33x33-bit products need no division.
    function automatic logic edge_crosses_ray(
        input logic signed [CW-1:0] x1,
        input logic signed [CW-1:0] y1,
        input logic signed [CW-1:0] x2,
        input logic signed [CW-1:0] y2,
        input logic signed [CW-1:0] px,
        input logic signed [CW-1:0] py
    );
        logic signed [CW:0]     da;
        logic signed [CW:0]     db;
        logic signed [CW:0]     dx1;
        logic signed [CW:0]     dy;
        logic signed [CW:0]     dx;
        logic signed [2*CW+2:0] num;
        da  = y1 - py;
        db  = y2 - py;
        dx1 = x1 - px;
        dy  = y1 - y2;
        dx  = x2 - x1;
        if (da[CW] == db[CW])
            return 1'b0;
        num = dx1 * dy + da * dx;
        if (!da[CW])
            return num > 0;
        return num < 0;
    endfunction

    always @(posedge i_clk) begin : watch
        bit want;
        if (!i_rst_n) begin
            query_x       = '0;
            query_y       = '0;
            odd_crossings = 1'b0;
            inside_expected.delete();
            o_fail_count  = 0;
            o_edges       = 0;
            o_results     = 0;
            o_writes      = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                o_writes++;
                case (i_cfg_index)
                    ppc_pkg::CFG_POINT_X: query_x = i_cfg_data[CW-1:0];
                    ppc_pkg::CFG_POINT_Y: query_y = i_cfg_data[CW-1:0];
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                o_results++;
                if (inside_expected.size() == 0) begin
                    $error("inside_res: word with no polygon pending, got %0d", o_inside_res);
                    o_fail_count++;
                end else begin
                    want = inside_expected.pop_front();
                    if (o_inside_res !== want) begin
                        $error("inside_res: expected %0d, got %0d", want, o_inside_res);
                        o_fail_count++;
                    end
                end
            end
            if (push && !full) begin
                o_edges++;
                if (edge_crosses_ray(i_edge_x1, i_edge_y1, i_edge_x2, i_edge_y2,
                                     query_x, query_y))
                    odd_crossings = ~odd_crossings;
                if (i_last_edge) begin
                    inside_expected.push_back(odd_crossings);
                    odd_crossings = 1'b0;
                end
            end
        end
        o_pending = inside_expected.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Bench top for point_in_polygon_crossing: clock, reset, query point writes,
// polygon edge streams, result popping with random stalls, and the verdict.
// Depends on ppc_pkg, the design files and ppc_checker.
module tb;

    localparam int CW            = ppc_pkg::COORD_BITS_DEFAULT;
    localparam int EDGE_TARGET   = 1150;
    localparam int PHASE_EDGES   = 110;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int PRESSURE_PHASE = 2;

    // Indexes past the register list; writes there must be ignored.
    localparam logic [ppc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [ppc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

    localparam int STY_GRID    = 0;
    localparam int STY_MEDIUM  = 1;
    localparam int STY_FULL    = 2;
    localparam int STY_EXTREME = 3;

    localparam logic [31:0] C_MIN  = 32'h8000_0000;
    localparam logic [31:0] C_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] C_ZERO = 32'h0000_0000;
    localparam logic [31:0] P1 = 32'h0001_0000;
    localparam logic [31:0] P2 = 32'h0002_0000;
    localparam logic [31:0] P3 = 32'h0003_0000;
    localparam logic [31:0] P5 = 32'h0005_0000;
    localparam logic [31:0] M1 = 32'hFFFF_0000;
    localparam logic [31:0] M2 = 32'hFFFE_0000;
    localparam logic [31:0] M3 = 32'hFFFD_0000;
    localparam logic [31:0] M5 = 32'hFFFB_0000;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [ppc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [ppc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                               push;
    logic                               full;
    logic [CW-1:0]                      i_edge_x1;
    logic [CW-1:0]                      i_edge_y1;
    logic [CW-1:0]                      i_edge_x2;
    logic [CW-1:0]                      i_edge_y2;
    logic                               i_last_edge;
    logic                               empty;
    logic                               pop;
    logic                               o_inside_res;

    int fail_count;
    int pending_results;
    int edges_seen;
    int results_seen;
    int writes_seen;

    int          edges_sent;
    int          send_burst;
    int          recv_burst;
    int          hold_token;
    int          hold_seen;
    logic [31:0] cur_px;
    logic [31:0] cur_py;

    point_in_polygon_crossing uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_edge_x1    (i_edge_x1),
        .i_edge_y1    (i_edge_y1),
        .i_edge_x2    (i_edge_x2),
        .i_edge_y2    (i_edge_y2),
        .i_last_edge  (i_last_edge),
        .empty        (empty),
        .pop          (pop),
        .o_inside_res (o_inside_res)
    );

    ppc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_edge_x1    (i_edge_x1),
        .i_edge_y1    (i_edge_y1),
        .i_edge_x2    (i_edge_x2),
        .i_edge_y2    (i_edge_y2),
        .i_last_edge  (i_last_edge),
        .empty        (empty),
        .pop          (pop),
        .o_inside_res (o_inside_res),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_edges      (edges_seen),
        .o_results    (results_seen),
        .o_writes     (writes_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // Coordinate around a center: a few LSBs off (hits exact-on-ray cases),
    // a moderate spread, anything, or a range end, zero, all ones or the center.
    function automatic logic [31:0] near(input logic [31:0] c, input int style);
        case (style)
            STY_GRID:   return c + $urandom_range(0, 8) - 32'd4;
            STY_MEDIUM: return c + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            STY_FULL:   return $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return C_ZERO;
                    3:       return 32'hFFFF_FFFF;
                    default: return c;
                endcase
            end
        endcase
    endfunction

    task automatic write_reg(input logic [ppc_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == ppc_pkg::CFG_POINT_X)
            cur_px = value;
        else if (idx == ppc_pkg::CFG_POINT_Y)
            cur_py = value;
        @(negedge i_clk);
    endtask

    task automatic send_edge(input logic [31:0] x1, input logic [31:0] y1,
                             input logic [31:0] x2, input logic [31:0] y2,
                             input logic last);
        int gap;
        if (send_burst > 0) begin
            gap = 0;
            send_burst--;
        end else begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 24) == 0)
                send_burst = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push        <= 1'b1;
        i_edge_x1   <= x1;
        i_edge_y1   <= y1;
        i_edge_x2   <= x2;
        i_edge_y2   <= y2;
        i_last_edge <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        edges_sent++;
    endtask

    // Hold the input until every predicted word has been popped, then let the
    // pipeline empty out behind edges that produce no word.
    task automatic drain();
        push <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Closed polygon of 3..8 vertices around the query point.
    task automatic send_polygon();
        logic [31:0] vx [0:7];
        logic [31:0] vy [0:7];
        int          k;
        int          s;
        int          j;
        k = $urandom_range(3, 8);
        s = $urandom_range(STY_GRID, STY_FULL);
        for (j = 0; j < k; j++) begin
            vx[j] = near(cur_px, ($urandom_range(0, 11) == 0) ? STY_EXTREME : s);
            vy[j] = near(cur_py, ($urandom_range(0, 11) == 0) ? STY_EXTREME : s);
        end
        for (j = 0; j < k; j++)
            send_edge(vx[j], vy[j], vx[(j + 1) % k], vy[(j + 1) % k], j == k - 1);
    endtask

    task automatic run_directed();
        // unit square around the origin: inside
        send_edge(M1, M1, P1, M1, 1'b0);
        send_edge(P1, M1, P1, P1, 1'b0);
        send_edge(P1, P1, M1, P1, 1'b0);
        send_edge(M1, P1, M1, M1, 1'b1);
        // edge running exactly through the point: no crossing
        send_edge(M1, M1, P1, P1, 1'b1);
        // horizontal edge lying on the ray
        send_edge(M5, C_ZERO, P5, C_ZERO, 1'b1);
        // vertex sitting on the ray, both directions
        send_edge(P3, C_ZERO, P3, M2, 1'b1);
        send_edge(P3, M2, P3, C_ZERO, 1'b1);
        // straddling edge left of the point
        send_edge(M3, M2, M3, P2, 1'b1);
        // two crossings cancel
        send_edge(P3, M2, P3, P2, 1'b0);
        send_edge(P5, P2, P5, M2, 1'b1);
        send_edge(C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b1);
        // widest differences
        send_edge(C_MAX, C_MAX, C_MIN, C_MIN, 1'b1);
        send_edge(C_MIN, C_MAX, C_MAX, C_MIN, 1'b1);
        drain();
        write_reg(ppc_pkg::CFG_POINT_X, C_MAX);
        write_reg(ppc_pkg::CFG_POINT_Y, C_MIN);
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        // nothing can sit below the lowest point
        send_edge(C_MIN, C_MIN, C_MAX, C_MAX, 1'b1);
        send_edge(C_MAX, C_MAX, C_MIN, C_MIN, 1'b1);
        drain();
        write_reg(ppc_pkg::CFG_POINT_X, C_MIN);
        write_reg(ppc_pkg::CFG_POINT_Y, C_MAX);
        send_edge(C_MAX, C_MIN, C_MAX, C_MAX, 1'b1);
        // crossing exactly at px
        send_edge(C_MIN, C_MIN, C_MIN, C_MAX, 1'b1);
    endtask

    task automatic run_phase(input int phase);
        int start;
        drain();
        if ($urandom_range(0, 3) != 0)
            write_reg(ppc_pkg::CFG_POINT_X,
                      near(C_ZERO, $urandom_range(STY_GRID, STY_EXTREME)));
        if ($urandom_range(0, 3) != 0)
            write_reg(ppc_pkg::CFG_POINT_Y,
                      near(C_ZERO, $urandom_range(STY_GRID, STY_EXTREME)));
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
        if (phase == PRESSURE_PHASE) begin
            // stall the popper and stream back-to-back closing edges
            hold_token++;
            send_burst = 80;
            repeat (60)
                send_edge(near(cur_px, STY_GRID), near(cur_py, STY_GRID),
                          near(cur_px, STY_MEDIUM), near(cur_py, STY_MEDIUM), 1'b1);
        end
        start = edges_sent;
        while (edges_sent - start < PHASE_EDGES) begin
            if ($urandom_range(0, 9) == 0)
                send_edge($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
            else
                send_polygon();
        end
    endtask

    initial begin : result_pop
        int gap;
        pop        = 1'b0;
        hold_seen  = 0;
        recv_burst = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (recv_burst > 0) begin
                gap = 0;
                recv_burst--;
            end else begin
                gap = $urandom_range(0, 16);
                if ($urandom_range(0, 24) == 0)
                    recv_burst = $urandom_range(10, 40);
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin : edge_feed
        int phase;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ppc_pkg::CFG_POINT_X;
        i_cfg_data  = '0;
        push        = 1'b0;
        i_edge_x1   = '0;
        i_edge_y1   = '0;
        i_edge_x2   = '0;
        i_edge_y2   = '0;
        i_last_edge = 1'b0;
        edges_sent  = 0;
        send_burst  = 0;
        hold_token  = 0;
        cur_px      = '0;
        cur_py      = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        phase = 0;
        while (edges_sent < EDGE_TARGET) begin
            run_phase(phase);
            phase++;
        end
        drain();
        $display("covered %0d edges, %0d inside words and %0d register writes over %0d phases,",
                 edges_seen, results_seen, writes_seen, phase);
        $display("including a %0d-cycle result stall with the edge input backed up",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
